// ===== design/bsd_pkg.sv =====
// bsd_pkg: shared types, constants and the character lookup for the base64 stream decoder
// used by the front, queue, back and top-level modules; no dependencies
package bsd_pkg;

  localparam int CFG_W          = 26;
  localparam logic [CFG_W-1:0] CFG_RESET = 26'h2000000;
  localparam int COUNT_BITS_DEF = 26;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_LENGTH   = 2'd1,
    ST_INVALID  = 2'd2,
    ST_OVERSIZE = 2'd3
  } status_t;

  // one decoded character
  typedef struct packed {
    logic       bad;
    logic       pad;
    logic [5:0] val;
  } sextet_t;

  // one group request from front to back: 1..3 bytes or a single status
  typedef struct packed {
    logic [23:0] bits;
    logic [1:0]  nbytes;
    status_t     status;
    logic        last;
  } group_rec_t;

  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t s;
    s.bad = 1'b0;
    s.pad = 1'b0;
    s.val = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      s.val = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s.val = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s.val = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      s.val = 6'd62;
    end else if (c == 8'h2F) begin
      s.val = 6'd63;
    end else if (c == 8'h3D) begin
      s.pad = 1'b1;
    end else begin
      s.bad = 1'b1;
    end
    return s;
  endfunction

endpackage

// ===== design/bsd_in_if.sv =====
// bsd_in_if: character channel into the decoder (valid/ready plus payload)
// no dependencies
interface bsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// ===== design/bsd_out_if.sv =====
// bsd_out_if: result channel out of the decoder (valid/ready plus payload)
// no dependencies
interface bsd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [1:0] status;
  logic       run_last;
  logic       stream_end;

  modport source (output valid, output data_byte, output status, output run_last,
                  output stream_end, input ready);
  modport sink   (input valid, input data_byte, input status, input run_last,
                  input stream_end, output ready);
endinterface

// ===== design/bsd_front.sv =====
// bsd_front: accepts characters, gathers groups, checks padding/length/size rules
// depends on bsd_pkg and bsd_in_if; pushes group requests to bsd_queue
module bsd_front
  import bsd_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  bsd_in_if.sink           in_ch,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             q_full,
  output logic             push,
  output group_rec_t       push_rec
);

  localparam int CMP_W = ((COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W) + 1;

  logic [CFG_W-1:0]      limit_cfg_r;
  logic [1:0]            pos_r, pos_nxt;
  logic [17:0]           bits_r, bits_nxt;
  logic                  pad2_r, pad2_nxt;
  logic                  ginv_r, ginv_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                  err_r, err_nxt;

  sextet_t     sx;
  logic        in_fire;
  logic        invalid;
  logic        oversize;
  logic        clear;
  logic [1:0]  nbytes;
  logic [CMP_W-1:0] cap, limit, sum;

  assign in_ch.ready = ~q_full;
  assign in_fire     = in_ch.valid & ~q_full;
  assign sx          = sextet_of(in_ch.char_code);

  assign nbytes = 2'd1 + {1'b0, ~pad2_r} + {1'b0, ~sx.pad};
  assign cap    = (CMP_W'(1) << COUNT_BITS) - CMP_W'(1);
  assign limit  = (CMP_W'(limit_cfg_r) > cap) ? cap : CMP_W'(limit_cfg_r);
  assign sum    = CMP_W'(cnt_r) + CMP_W'(nbytes);
  assign oversize = sum > limit;

  // rules checked when the fourth character arrives
  assign invalid = ginv_r | sx.bad | (pad2_r & ~sx.pad) |
                   (~in_ch.last_char & (pad2_r | sx.pad));

  always_comb begin
    pos_nxt  = pos_r;
    bits_nxt = bits_r;
    pad2_nxt = pad2_r;
    ginv_nxt = ginv_r;
    cnt_nxt  = cnt_r;
    err_nxt  = err_r;
    clear    = 1'b0;
    push     = 1'b0;
    push_rec.bits   = 24'd0;
    push_rec.nbytes = 2'd1;
    push_rec.status = ST_OK;
    push_rec.last   = 1'b1;
    if (in_fire) begin
      if (err_r) begin
        clear = in_ch.last_char;
      end else if (pos_r != 2'd3) begin
        if (pos_r != 2'd2 && (sx.bad || sx.pad)) ginv_nxt = 1'b1;
        if (pos_r == 2'd2 && sx.bad) ginv_nxt = 1'b1;
        if (pos_r == 2'd2 && sx.pad) pad2_nxt = 1'b1;
        bits_nxt = {bits_r[11:0], sx.val};
        pos_nxt  = pos_r + 2'd1;
        if (in_ch.last_char) begin
          push            = 1'b1;
          push_rec.status = ST_LENGTH;
          clear           = 1'b1;
        end
      end else begin
        pos_nxt  = 2'd0;
        bits_nxt = 18'd0;
        pad2_nxt = 1'b0;
        ginv_nxt = 1'b0;
        push     = 1'b1;
        if (invalid || oversize) begin
          push_rec.status = invalid ? ST_INVALID : ST_OVERSIZE;
          if (in_ch.last_char) clear = 1'b1;
          else err_nxt = 1'b1;
        end else begin
          push_rec.bits   = {bits_r, sx.val};
          push_rec.nbytes = nbytes;
          push_rec.last   = in_ch.last_char;
          cnt_nxt         = sum[COUNT_BITS-1:0];
          clear           = in_ch.last_char;
        end
      end
    end
    if (clear) begin
      pos_nxt  = 2'd0;
      bits_nxt = 18'd0;
      pad2_nxt = 1'b0;
      ginv_nxt = 1'b0;
      cnt_nxt  = '0;
      err_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_cfg_r <= CFG_RESET;
      pos_r       <= 2'd0;
      bits_r      <= 18'd0;
      pad2_r      <= 1'b0;
      ginv_r      <= 1'b0;
      cnt_r       <= '0;
      err_r       <= 1'b0;
    end else begin
      if (cfg_we) limit_cfg_r <= cfg_wdata;
      pos_r  <= pos_nxt;
      bits_r <= bits_nxt;
      pad2_r <= pad2_nxt;
      ginv_r <= ginv_nxt;
      cnt_r  <= cnt_nxt;
      err_r  <= err_nxt;
    end
  end

endmodule

// ===== design/bsd_queue.sv =====
// bsd_queue: short fifo of group requests between front and back
// depends on bsd_pkg
module bsd_queue
  import bsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  group_rec_t push_rec,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output group_rec_t head_rec
);

  group_rec_t         mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;

  assign full       = cnt_r == Q_CNT_W'(Q_DEPTH);
  assign head_valid = cnt_r != '0;
  assign head_rec   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      if (pop) rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      if (push && !pop) cnt_r <= cnt_r + Q_CNT_W'(1);
      else if (pop && !push) cnt_r <= cnt_r - Q_CNT_W'(1);
    end
  end

endmodule

// ===== design/bsd_back.sv =====
// bsd_back: turns each group request into one to three results
// depends on bsd_pkg and bsd_out_if; reads the head of bsd_queue
module bsd_back
  import bsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  group_rec_t head_rec,
  output logic       pop,
  bsd_out_if.source  out_ch
);

  logic [1:0] k_r, k_nxt;
  logic       out_fire;
  logic       final_k;

  assign final_k  = (k_r + 2'd1) == head_rec.nbytes;
  assign out_fire = head_valid & out_ch.ready;
  assign pop      = out_fire & final_k;

  assign out_ch.valid      = head_valid;
  assign out_ch.status     = head_rec.status;
  assign out_ch.run_last   = final_k;
  assign out_ch.stream_end = final_k & head_rec.last;

  always_comb begin
    unique case (k_r)
      2'd0:    out_ch.data_byte = head_rec.bits[23:16];
      2'd1:    out_ch.data_byte = head_rec.bits[15:8];
      default: out_ch.data_byte = head_rec.bits[7:0];
    endcase
  end

  always_comb begin
    k_nxt = k_r;
    if (out_fire) k_nxt = final_k ? 2'd0 : k_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= 2'd0;
    end else begin
      k_r <= k_nxt;
    end
  end

endmodule

// ===== design/base64_stream_decoder_core.sv =====
// base64_stream_decoder_core: strict base64 decoder, one character in, bytes or status out
// depends on bsd_pkg, bsd_in_if, bsd_out_if, bsd_front, bsd_queue, bsd_back
//
//   channel  dir  handshake         payload
//   in_ch    in   valid/ready       char_code[7:0], last_char
//   out_ch   out  valid/ready       data_byte[7:0], status[1:0], run_last, stream_end
//   cfg      in   cfg_we            cfg_wdata[25:0] (max decoded bytes)
//
// one character is taken per cycle while the 4-entry group queue has room
// each completed group leaves as 1 to 3 results, one per cycle while out_ch is ready, from the queue head
// a result waiting on out_ch does not stop input until the queue fills
// synchronous active-low reset clears stream state; byte limit returns to 2^25
module base64_stream_decoder_core
  import bsd_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  bsd_in_if.sink           in_ch,
  bsd_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  logic       q_full;
  logic       push;
  group_rec_t push_rec;
  logic       pop;
  logic       head_valid;
  group_rec_t head_rec;

  bsd_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .q_full   (q_full),
    .push     (push),
    .push_rec (push_rec)
  );

  bsd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_rec  (push_rec),
    .full      (q_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_rec  (head_rec)
  );

  bsd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head_rec  (head_rec),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule
